FILE: rtl/core/gld_pkg.sv
// Shared types, status codes and defaults for the GIF LZW decoder.
package gld_pkg;

	localparam int unsigned MAX_CODE_BITS_DEF = 12;
	localparam int unsigned STACK_DEPTH_DEF   = 2048;
	localparam logic [3:0]  MIN_SIZE_RESET    = 4'd8;

	typedef enum logic [2:0] {
		ST_PIXEL   = 3'd0,
		ST_TAKEN   = 3'd1,
		ST_REFUSED = 3'd2,
		ST_NEED    = 3'd3,
		ST_END     = 3'd4,
		ST_ERROR   = 3'd5
	} status_t;

	typedef enum logic [0:0] {
		OP_PUSH = 1'b0,
		OP_PULL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_WALK,
		S_WALK_RD,
		S_EMIT
	} state_t;

endpackage

FILE: rtl/core/gld_item_if.sv
// Input channel: one push or pull item per transfer.
interface gld_item_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

FILE: rtl/core/gld_result_if.sv
// Output channel: one status and pixel index per transfer.
interface gld_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] pixel_index;

	modport source (output valid, output status, output pixel_index, input ready);
	modport sink (input valid, input status, input pixel_index, output ready);
endinterface

FILE: rtl/core/gif_lzw_decoder.sv
// GIF LZW decoder: push transfers feed raw image-data bytes (sub-block length bytes included),
// pull transfers return one pixel index each, with one status per item. A pull that pops a
// stacked pixel goes through accept, stack read and result. A pull that starts a new code
// walks its prefix chain, where every chain step reads the code table memory once and writes
// the string stack once; the first pixel is then popped. Each clear code is consumed in a
// decode step of its own. The code table needs no clearing pass: only entries below the next
// free code are ever read. Results wait in an output register; while one is not yet taken,
// the next result waits and the input stays blocked until the register frees.
module gif_lzw_decoder #(
	parameter int unsigned MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
	parameter int unsigned STACK_DEPTH   = gld_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [3:0]    cfg_data,
	gld_item_if.sink      item,
	gld_result_if.source  result
);

	localparam int unsigned CLW        = MAX_CODE_BITS + 1;
	localparam int unsigned TABLE_SIZE = 1 << MAX_CODE_BITS;
	localparam int unsigned SPW        = $clog2(STACK_DEPTH + 1);
	localparam int unsigned SAW        = $clog2(STACK_DEPTH);
	localparam int unsigned TW         = MAX_CODE_BITS + 8;

	// state registers
	gld_pkg::state_t            state_q, state_d;
	logic [3:0]                 min_size_q;
	logic [31:0]                acc_q, acc_d;
	logic [5:0]                 bits_q, bits_d;
	logic [7:0]                 sub_left_q, sub_left_d;
	logic                       ended_q, ended_d;
	logic                       clr_pend_q, clr_pend_d;
	logic [3:0]                 cwidth_q, cwidth_d;
	logic [CLW-1:0]             next_free_q, next_free_d;
	logic [CLW-1:0]             wlimit_q, wlimit_d;
	logic [7:0]                 first_char_q, first_char_d;
	logic [MAX_CODE_BITS-1:0]   prev_code_q, prev_code_d;
	logic [MAX_CODE_BITS-1:0]   incode_q, incode_d;
	logic [MAX_CODE_BITS-1:0]   cur_q, cur_d;
	logic [SPW-1:0]             sp_q, sp_d;
	logic                       out_valid_q, out_valid_d;
	logic [2:0]                 out_status_q, out_status_d;
	logic [7:0]                 out_pixel_q, out_pixel_d;
	logic [2:0]                 hold_status_q, hold_status_d;
	logic [7:0]                 hold_pixel_q, hold_pixel_d;

	// memory ports
	logic                       stk_we;
	logic [SAW-1:0]             stk_waddr, stk_raddr;
	logic [7:0]                 stk_wdata, stk_rdata;
	logic                       tbl_we;
	logic [MAX_CODE_BITS-1:0]   tbl_waddr, tbl_raddr;
	logic [TW-1:0]              tbl_wdata, tbl_rdata;

	// decode helpers
	logic [3:0]                 eff_size;
	logic [CLW-1:0]             clear_code;
	logic [CLW-1:0]             code_mask;
	logic [MAX_CODE_BITS-1:0]   code;
	logic [CLW-1:0]             code_x;
	logic [CLW-1:0]             cur_x;
	logic [CLW-1:0]             link_x;
	logic                       out_free;
	logic                       res_valid;
	logic [2:0]                 res_status;
	logic [7:0]                 res_pixel;

	gld_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	gld_ram #(.WIDTH(TW), .DEPTH(TABLE_SIZE)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// effective code size, clear code and the current code in the accumulator
	always_comb begin
		if (min_size_q == 4'd0) begin
			eff_size = 4'd1;
		end else if (min_size_q > 4'd8) begin
			eff_size = 4'd8;
		end else begin
			eff_size = min_size_q;
		end
		clear_code = CLW'(1) << eff_size;
		code_mask  = (CLW'(1) << cwidth_q) - CLW'(1);
		code       = acc_q[MAX_CODE_BITS-1:0] & code_mask[MAX_CODE_BITS-1:0];
		code_x     = CLW'(code);
		cur_x      = CLW'(cur_q);
		link_x     = CLW'(tbl_rdata[TW-1:8]);
	end

	assign out_free     = !out_valid_q || result.ready;
	assign item.ready   = (state_q == gld_pkg::S_IDLE);
	assign result.valid = out_valid_q;
	assign result.status      = out_status_q;
	assign result.pixel_index = out_pixel_q;

	// sequencer: next state, datapath updates and memory accesses
	always_comb begin
		state_d       = state_q;
		acc_d         = acc_q;
		bits_d        = bits_q;
		sub_left_d    = sub_left_q;
		ended_d       = ended_q;
		clr_pend_d    = clr_pend_q;
		cwidth_d      = cwidth_q;
		next_free_d   = next_free_q;
		wlimit_d      = wlimit_q;
		first_char_d  = first_char_q;
		prev_code_d   = prev_code_q;
		incode_d      = incode_q;
		cur_d         = cur_q;
		sp_d          = sp_q;
		hold_status_d = hold_status_q;
		hold_pixel_d  = hold_pixel_q;
		res_valid     = 1'b0;
		res_status    = gld_pkg::ST_PIXEL;
		res_pixel     = 8'd0;
		stk_we        = 1'b0;
		stk_waddr     = sp_q[SAW-1:0];
		stk_wdata     = 8'd0;
		stk_raddr     = SAW'(sp_q - SPW'(1));
		tbl_we        = 1'b0;
		tbl_waddr     = next_free_q[MAX_CODE_BITS-1:0];
		tbl_wdata     = {prev_code_q, first_char_q};
		tbl_raddr     = cur_q;

		unique case (state_q)
			gld_pkg::S_IDLE: begin
				if (item.valid) begin
					if (item.operation == gld_pkg::OP_PULL) begin
						state_d = gld_pkg::S_DECODE;
					end else begin
						res_valid = 1'b1;
						if (ended_q) begin
							res_status = gld_pkg::ST_REFUSED;
						end else if (sub_left_q == 8'd0) begin
							res_status = gld_pkg::ST_TAKEN;
							if (item.data_byte == 8'd0) begin
								ended_d = 1'b1;
							end else begin
								sub_left_d = item.data_byte;
							end
						end else if (bits_q > 6'd24) begin
							res_status = gld_pkg::ST_REFUSED;
						end else begin
							res_status = gld_pkg::ST_TAKEN;
							acc_d      = acc_q | (32'(item.data_byte) << bits_q);
							bits_d     = bits_q + 6'd8;
							sub_left_d = sub_left_q - 8'd1;
						end
					end
				end
			end

			gld_pkg::S_DECODE: begin
				if (sp_q != SPW'(0)) begin
					// pop the top of the stack
					sp_d    = sp_q - SPW'(1);
					state_d = gld_pkg::S_POP;
				end else if (bits_q < 6'(cwidth_q)) begin
					res_valid  = 1'b1;
					res_status = ended_q ? gld_pkg::ST_ERROR : gld_pkg::ST_NEED;
				end else if (code_x == clear_code + CLW'(1)) begin
					res_valid  = 1'b1;
					res_status = gld_pkg::ST_END;
				end else begin
					acc_d  = acc_q >> cwidth_q;
					bits_d = bits_q - 6'(cwidth_q);
					if (code_x == clear_code) begin
						// reset table, width and stack, then read the next code
						cwidth_d    = eff_size + 4'd1;
						next_free_d = clear_code + CLW'(2);
						wlimit_d    = clear_code << 1;
						clr_pend_d  = 1'b1;
						sp_d        = SPW'(0);
					end else if (clr_pend_q) begin
						res_valid = 1'b1;
						if (code_x > clear_code) begin
							res_status = gld_pkg::ST_ERROR;
						end else begin
							first_char_d = code[7:0];
							prev_code_d  = code;
							clr_pend_d   = 1'b0;
							res_status   = gld_pkg::ST_PIXEL;
							res_pixel    = code[7:0];
						end
					end else if (code_x > next_free_q) begin
						res_valid  = 1'b1;
						res_status = gld_pkg::ST_ERROR;
					end else begin
						incode_d = code;
						state_d  = gld_pkg::S_WALK;
						if (code_x == next_free_q) begin
							// string not yet in table: repeat its first character
							stk_we    = 1'b1;
							stk_wdata = first_char_q;
							sp_d      = sp_q + SPW'(1);
							cur_d     = prev_code_q;
						end else begin
							cur_d = code;
						end
					end
				end
			end

			gld_pkg::S_POP: begin
				res_valid  = 1'b1;
				res_status = gld_pkg::ST_PIXEL;
				res_pixel  = stk_rdata;
			end

			gld_pkg::S_WALK: begin
				if (sp_q >= SPW'(STACK_DEPTH)) begin
					sp_d       = SPW'(0);
					res_valid  = 1'b1;
					res_status = gld_pkg::ST_ERROR;
				end else if (cur_x >= clear_code) begin
					// fetch link and suffix of this chain entry
					state_d = gld_pkg::S_WALK_RD;
				end else begin
					// chain root: stack it and add the new table entry while the table has room
					stk_we       = 1'b1;
					stk_wdata    = cur_q[7:0];
					sp_d         = sp_q + SPW'(1);
					first_char_d = cur_q[7:0];
					if (next_free_q < CLW'(TABLE_SIZE)) begin
						tbl_we      = 1'b1;
						tbl_wdata   = {prev_code_q, cur_q[7:0]};
						next_free_d = next_free_q + CLW'(1);
						if ((next_free_q + CLW'(1) >= wlimit_q) &&
						    (wlimit_q < CLW'(TABLE_SIZE))) begin
							wlimit_d = wlimit_q << 1;
							cwidth_d = cwidth_q + 4'd1;
						end
					end
					prev_code_d = incode_q;
					state_d     = gld_pkg::S_DECODE;
				end
			end

			gld_pkg::S_WALK_RD: begin
				stk_we    = 1'b1;
				stk_wdata = tbl_rdata[7:0];
				sp_d      = sp_q + SPW'(1);
				cur_d     = link_x[MAX_CODE_BITS-1:0];
				state_d   = gld_pkg::S_WALK;
			end

			gld_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = gld_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = gld_pkg::S_IDLE;
			end
		endcase

		// hand the result to the output register, or hold it until the slot frees
		out_valid_d  = out_valid_q && !result.ready;
		out_status_d = out_status_q;
		out_pixel_d  = out_pixel_q;
		if (state_q == gld_pkg::S_EMIT && out_free) begin
			out_valid_d  = 1'b1;
			out_status_d = hold_status_q;
			out_pixel_d  = hold_pixel_q;
		end else if (res_valid) begin
			if (out_free) begin
				out_valid_d  = 1'b1;
				out_status_d = res_status;
				out_pixel_d  = res_pixel;
				state_d      = gld_pkg::S_IDLE;
			end else begin
				hold_status_d = res_status;
				hold_pixel_d  = res_pixel;
				state_d       = gld_pkg::S_EMIT;
			end
		end
	end

	// state update; a code size write restarts decoding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gld_pkg::S_IDLE;
			min_size_q   <= gld_pkg::MIN_SIZE_RESET;
			acc_q        <= '0;
			bits_q       <= '0;
			sub_left_q   <= '0;
			ended_q      <= 1'b0;
			clr_pend_q   <= 1'b1;
			cwidth_q     <= gld_pkg::MIN_SIZE_RESET + 4'd1;
			next_free_q  <= (CLW'(1) << gld_pkg::MIN_SIZE_RESET) + CLW'(2);
			wlimit_q     <= CLW'(1) << (gld_pkg::MIN_SIZE_RESET + 4'd1);
			first_char_q <= '0;
			prev_code_q  <= '0;
			incode_q     <= '0;
			cur_q        <= '0;
			sp_q         <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_pixel_q  <= '0;
			hold_status_q <= '0;
			hold_pixel_q <= '0;
		end else if (cfg_we) begin
			min_size_q   <= cfg_data;
			acc_q        <= '0;
			bits_q       <= '0;
			sub_left_q   <= '0;
			ended_q      <= 1'b0;
			clr_pend_q   <= 1'b1;
			first_char_q <= '0;
			prev_code_q  <= '0;
			sp_q         <= '0;
			if (cfg_data == 4'd0) begin
				cwidth_q    <= 4'd2;
				next_free_q <= CLW'(4);
				wlimit_q    <= CLW'(4);
			end else if (cfg_data > 4'd8) begin
				cwidth_q    <= 4'd9;
				next_free_q <= CLW'(258);
				wlimit_q    <= CLW'(512);
			end else begin
				cwidth_q    <= cfg_data + 4'd1;
				next_free_q <= (CLW'(1) << cfg_data) + CLW'(2);
				wlimit_q    <= CLW'(1) << (cfg_data + 4'd1);
			end
			out_valid_q  <= out_valid_d;
		end else begin
			state_q      <= state_d;
			acc_q        <= acc_d;
			bits_q       <= bits_d;
			sub_left_q   <= sub_left_d;
			ended_q      <= ended_d;
			clr_pend_q   <= clr_pend_d;
			cwidth_q     <= cwidth_d;
			next_free_q  <= next_free_d;
			wlimit_q     <= wlimit_d;
			first_char_q <= first_char_d;
			prev_code_q  <= prev_code_d;
			incode_q     <= incode_d;
			cur_q        <= cur_d;
			sp_q         <= sp_d;
			out_valid_q  <= out_valid_d;
			out_status_q <= out_status_d;
			out_pixel_q  <= out_pixel_d;
			hold_status_q <= hold_status_d;
			hold_pixel_q <= hold_pixel_d;
		end
	end

endmodule

FILE: rtl/core/gld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gld_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
